// ===== rtl/ddo_pkg.sv =====
// Shared constants, types and helper functions for the differential drive odometry core.
// No dependencies; the other files of the block, apart from ddo_if, refer to this package by scoped names.
`default_nettype none

package ddo_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int CNT_W        = $clog2(CORDIC_STEPS);
	localparam int CW           = 36;   // CORDIC datapath width, Q2.30 plus headroom

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] CFG_METERS_PER_TICK = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_WHEEL_BASE  = 1'd1;

	localparam logic [23:0] MPT_RESET = 24'd7457;
	localparam logic [23:0] IWB_RESET = 24'd292571;

	localparam logic signed [19:0] PI_Q16      = 20'sd205887;
	localparam logic signed [19:0] TWO_PI_Q16  = 20'sd411774;
	localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102943;
	localparam logic signed [41:0] ONE_Q16     = 42'sd65536;
	localparam logic signed [CW-1:0] INV_GAIN_Q30 = 36'sd652032874;

	typedef logic signed [19:0] angle_t;

	function automatic logic [29:0] atan_q30(input logic [4:0] i);
		case (i)
			5'd0:  return 30'd843314857;
			5'd1:  return 30'd497837829;
			5'd2:  return 30'd263043837;
			5'd3:  return 30'd133525159;
			5'd4:  return 30'd67021687;
			5'd5:  return 30'd33543516;
			5'd6:  return 30'd16775851;
			5'd7:  return 30'd8388437;
			5'd8:  return 30'd4194283;
			5'd9:  return 30'd2097149;
			5'd10: return 30'd1048576;
			5'd11: return 30'd524288;
			5'd12: return 30'd262144;
			5'd13: return 30'd131072;
			5'd14: return 30'd65536;
			5'd15: return 30'd32768;
			5'd16: return 30'd16384;
			5'd17: return 30'd8192;
			5'd18: return 30'd4096;
			5'd19: return 30'd2048;
			5'd20: return 30'd1024;
			5'd21: return 30'd512;
			5'd22: return 30'd256;
			5'd23: return 30'd128;
			default: return 30'd0;
		endcase
	endfunction

	// arithmetic right shift, rounding half away from zero
	function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
			input int unsigned n);
		logic signed [63:0] h;
		h = 64'sd1 <<< (n - 1);
		return (v + (v[63] ? h - 64'sd1 : h)) >>> n;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
		if (v > 35'sd2147483647)
			return 32'sh7fffffff;
		if (v < -35'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic angle_t wrap_pi(input angle_t a);
		if (a > PI_Q16)
			return a - TWO_PI_Q16;
		if (a < -PI_Q16)
			return a + TWO_PI_Q16;
		return a;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/ddo_if.sv =====
// Valid/ready channel interfaces for the odometry core: sample/command in, pose out.
// No dependencies.
`default_nettype none

interface ddo_in_if;
	logic               valid;
	logic               ready;
	logic               command;
	logic signed [15:0] left_count;
	logic signed [15:0] right_count;
	logic signed [31:0] new_x;
	logic signed [31:0] new_y;
	logic signed [18:0] new_heading;

	modport source (output valid, command, left_count, right_count, new_x, new_y,
		new_heading, input ready);
	modport sink (input valid, command, left_count, right_count, new_x, new_y,
		new_heading, output ready);
endinterface

interface ddo_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [18:0] heading;
	logic               pose_valid;
	logic               step_rejected;

	modport source (output valid, pos_x, pos_y, heading, pose_valid, step_rejected,
		input ready);
	modport sink (input valid, pos_x, pos_y, heading, pose_valid, step_rejected,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/ddo_cordic_step.sv =====
// One CORDIC micro-rotation, shared by the arcsine (vectoring) and sine/cosine (rotation) passes.
// Depends on ddo_pkg for the datapath width and the arctangent table.
`default_nettype none

module ddo_cordic_step (
	input  wire logic                           vectoring,
	input  wire logic        [ddo_pkg::CNT_W-1:0] idx,
	input  wire logic signed [ddo_pkg::CW-1:0]  x,
	input  wire logic signed [ddo_pkg::CW-1:0]  y,
	input  wire logic signed [ddo_pkg::CW-1:0]  z,
	output logic signed      [ddo_pkg::CW-1:0]  nx,
	output logic signed      [ddo_pkg::CW-1:0]  ny,
	output logic signed      [ddo_pkg::CW-1:0]  nz
);

	logic signed [ddo_pkg::CW-1:0] xs, ys, at;
	logic                          pos;

	always_comb begin
		xs = x >>> idx;
		ys = y >>> idx;
		at = $signed(ddo_pkg::CW'(ddo_pkg::atan_q30(5'(idx))));
		// vectoring drives y toward zero, rotation drives z toward zero
		pos = vectoring ? !(y > 0) : (z >= 0);
		if (pos) begin
			nx = x - ys;
			ny = y + xs;
			nz = z - at;
		end else begin
			nx = x + ys;
			ny = y - xs;
			nz = z + at;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/differential_drive_odometry_core.sv =====
// Flow: a pose-set item goes straight from idle to the output state; an encoder sample is
// checked on its arcsine argument and, unless the step is rejected there, goes on to a 17-step
// square root and two passes through the single CORDIC stage, all on one shared 32x32 multiplier.
// Throughput: one item at a time; the input is ready only while the sequencer is idle.
// A sample before any pose set is absorbed with no result; it only updates the stored counts.
// Reset (arst_n low, asynchronous) clears pose, counters, flags and loads register defaults.
`default_nettype none

module differential_drive_odometry_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [ddo_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ddo_pkg::CFG_DATA_W-1:0] cfg_data,
	ddo_in_if.sink                             in_ch,
	ddo_out_if.source                          out_ch
);

	typedef enum logic [4:0] {
		IDLE, MUL_L, MUL_R, SUMS, RND, MUL_LO, MUL_HI, PSUM, ARG, SQ, SQN, ROOT, VINIT,
		VEC, ANG, MID, ROTI, ROT, TRIG, MUL_X, MUL_Y, ACC_X, FIN, OUT
	} state_t;

	localparam logic [ddo_pkg::CNT_W-1:0] LAST_STEP = ddo_pkg::CNT_W'(ddo_pkg::CORDIC_STEPS - 1);

	state_t state_q;

	logic [23:0] mpt_q, iwb_q;
	logic [15:0] last_left_q, last_right_q;
	logic        have_last_q, started_q;
	logic signed [31:0] x_acc_q, y_acc_q;
	ddo_pkg::angle_t    theta_q, theta_nx_q, ang_q, mid_q;

	logic signed [15:0] dl_q, dr_q;
	logic signed [63:0] prod_q;
	logic signed [39:0] ml_q;
	logic        [39:0] plo_q;
	logic signed [40:0] dsum_q, msum_q;
	logic signed [32:0] diff_q;
	logic signed [31:0] mean_q, co_q, si_q;
	logic signed [57:0] psum_q;
	logic signed [17:0] s_q;
	logic        [33:0] n_q, r_q, bit_q;
	logic signed [ddo_pkg::CW-1:0] cx_q, cy_q, cz_q;
	logic [ddo_pkg::CNT_W-1:0] cnt_q;
	logic        flip_q, rej_q;
	logic signed [33:0] dx_q, dy_q;

	logic        ov_q, opv_q, orej_q;
	logic signed [31:0] ox_q, oy_q;
	logic signed [18:0] oh_q;

	logic signed [31:0] mul_a, mul_b;
	logic signed [ddo_pkg::CW-1:0] nx, ny, nz;
	logic signed [41:0] arg;
	logic        [33:0] root_t;
	logic signed [ddo_pkg::CW-1:0] neg_x, neg_y;
	ddo_pkg::angle_t    red_a;
	logic               red_flip;

	ddo_cordic_step u_step (
		.vectoring (state_q == VEC),
		.idx       (cnt_q),
		.x         (cx_q),
		.y         (cy_q),
		.z         (cz_q),
		.nx        (nx),
		.ny        (ny),
		.nz        (nz)
	);

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			MUL_L: begin
				mul_a = 32'(dl_q);
				mul_b = $signed({8'd0, mpt_q});
			end
			MUL_R: begin
				mul_a = 32'(dr_q);
				mul_b = $signed({8'd0, mpt_q});
			end
			MUL_LO: begin
				mul_a = $signed({16'd0, diff_q[15:0]});
				mul_b = $signed({8'd0, iwb_q});
			end
			MUL_HI: begin
				mul_a = 32'($signed(diff_q[32:16]));
				mul_b = $signed({8'd0, iwb_q});
			end
			SQ: begin
				mul_a = 32'(s_q);
				mul_b = 32'(s_q);
			end
			MUL_X: begin
				mul_a = mean_q;
				mul_b = co_q;
			end
			MUL_Y: begin
				mul_a = mean_q;
				mul_b = si_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		arg    = 42'(ddo_pkg::rnd_shr(64'(psum_q), 16));
		root_t = r_q + bit_q;
		neg_x  = -cx_q;
		neg_y  = -cy_q;
		red_a    = mid_q;
		red_flip = 1'b0;
		if (mid_q > ddo_pkg::HALF_PI_Q16) begin
			red_a    = mid_q - ddo_pkg::PI_Q16;
			red_flip = 1'b1;
		end else if (mid_q < -ddo_pkg::HALF_PI_Q16) begin
			red_a    = mid_q + ddo_pkg::PI_Q16;
			red_flip = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mpt_q <= ddo_pkg::MPT_RESET;
			iwb_q <= ddo_pkg::IWB_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				ddo_pkg::CFG_METERS_PER_TICK: mpt_q <= cfg_data;
				ddo_pkg::CFG_INV_WHEEL_BASE:  iwb_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk)
		prod_q <= mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= IDLE;
			last_left_q  <= '0;
			last_right_q <= '0;
			have_last_q  <= 1'b0;
			started_q    <= 1'b0;
			x_acc_q      <= '0;
			y_acc_q      <= '0;
			theta_q      <= '0;
			rej_q        <= 1'b0;
			ov_q         <= 1'b0;
		end else begin
			if (ov_q && out_ch.ready && state_q != OUT)
				ov_q <= 1'b0;
			case (state_q)
				IDLE: begin
					if (in_ch.valid) begin
						if (in_ch.command) begin
							x_acc_q   <= in_ch.new_x;
							y_acc_q   <= in_ch.new_y;
							theta_q   <= ddo_pkg::wrap_pi(20'(in_ch.new_heading));
							started_q <= 1'b1;
							rej_q     <= 1'b0;
							state_q   <= OUT;
						end else begin
							dl_q <= have_last_q ?
								$signed(16'(in_ch.left_count) - last_left_q) : 16'sd0;
							dr_q <= have_last_q ?
								$signed(16'(in_ch.right_count) - last_right_q) : 16'sd0;
							last_left_q  <= in_ch.left_count;
							last_right_q <= in_ch.right_count;
							have_last_q  <= 1'b1;
							if (started_q)
								state_q <= MUL_L;
						end
					end
				end
				MUL_L: state_q <= MUL_R;
				MUL_R: begin
					ml_q    <= prod_q[39:0];
					state_q <= SUMS;
				end
				SUMS: begin
					dsum_q  <= 41'($signed(prod_q[39:0])) - 41'(ml_q);
					msum_q  <= 41'($signed(prod_q[39:0])) + 41'(ml_q);
					state_q <= RND;
				end
				RND: begin
					diff_q  <= 33'(ddo_pkg::rnd_shr(64'(dsum_q), 8));
					mean_q  <= 32'(ddo_pkg::rnd_shr(64'(msum_q), 9));
					state_q <= MUL_LO;
				end
				MUL_LO: state_q <= MUL_HI;
				MUL_HI: begin
					plo_q   <= prod_q[39:0];
					state_q <= PSUM;
				end
				PSUM: begin
					psum_q  <= $signed({prod_q[41:0], 16'd0}) + $signed({18'd0, plo_q});
					state_q <= ARG;
				end
				ARG: begin
					if (arg > ddo_pkg::ONE_Q16 || arg < -ddo_pkg::ONE_Q16) begin
						rej_q   <= 1'b1;
						state_q <= OUT;
					end else begin
						s_q     <= arg[17:0];
						state_q <= SQ;
					end
				end
				SQ: state_q <= SQN;
				SQN: begin
					n_q     <= 34'h1_0000_0000 - {1'b0, prod_q[32:0]};
					r_q     <= '0;
					bit_q   <= 34'h1_0000_0000;
					state_q <= ROOT;
				end
				ROOT: begin
					// one result bit per cycle, floor square root
					if (n_q >= root_t) begin
						n_q <= n_q - root_t;
						r_q <= (r_q >> 1) + bit_q;
					end else begin
						r_q <= r_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q[0])
						state_q <= VINIT;
				end
				VINIT: begin
					cx_q    <= $signed(ddo_pkg::CW'(r_q[16:0]) << 14);
					cy_q    <= ddo_pkg::CW'(s_q) <<< 14;
					cz_q    <= '0;
					cnt_q   <= '0;
					state_q <= VEC;
				end
				VEC, ROT: begin
					cx_q  <= nx;
					cy_q  <= ny;
					cz_q  <= nz;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_STEP)
						state_q <= (state_q == VEC) ? ANG : TRIG;
				end
				ANG: begin
					ang_q   <= 20'(ddo_pkg::rnd_shr(64'(cz_q), 14));
					state_q <= MID;
				end
				MID: begin
					mid_q      <= ddo_pkg::wrap_pi(theta_q + (ang_q >>> 1));
					theta_nx_q <= ddo_pkg::wrap_pi(theta_q + ang_q);
					state_q    <= ROTI;
				end
				ROTI: begin
					cx_q    <= ddo_pkg::INV_GAIN_Q30;
					cy_q    <= '0;
					cz_q    <= ddo_pkg::CW'(red_a) <<< 14;
					flip_q  <= red_flip;
					cnt_q   <= '0;
					state_q <= ROT;
				end
				TRIG: begin
					co_q    <= flip_q ? neg_x[31:0] : cx_q[31:0];
					si_q    <= flip_q ? neg_y[31:0] : cy_q[31:0];
					state_q <= MUL_X;
				end
				MUL_X: state_q <= MUL_Y;
				MUL_Y: begin
					dx_q    <= 34'(ddo_pkg::rnd_shr(prod_q, 30));
					state_q <= ACC_X;
				end
				ACC_X: begin
					dy_q    <= 34'(ddo_pkg::rnd_shr(prod_q, 30));
					x_acc_q <= ddo_pkg::sat32(35'(x_acc_q) + 35'(dx_q));
					state_q <= FIN;
				end
				FIN: begin
					y_acc_q <= ddo_pkg::sat32(35'(y_acc_q) + 35'(dy_q));
					theta_q <= theta_nx_q;
					rej_q   <= 1'b0;
					state_q <= OUT;
				end
				OUT: begin
					// wait for the output slot to free up
					if (!ov_q || out_ch.ready) begin
						ov_q    <= 1'b1;
						ox_q    <= x_acc_q;
						oy_q    <= y_acc_q;
						oh_q    <= theta_q[18:0];
						opv_q   <= 1'b1;
						orej_q  <= rej_q;
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign in_ch.ready          = (state_q == IDLE);
	assign out_ch.valid         = ov_q;
	assign out_ch.pos_x         = ox_q;
	assign out_ch.pos_y         = oy_q;
	assign out_ch.heading       = oh_q;
	assign out_ch.pose_valid    = opv_q;
	assign out_ch.step_rejected = orej_q;

endmodule

`default_nettype wire

// ===== rtl/ddo_checker.sv =====
// Port-level checks for the odometry core, attached to the top level by bind.
// Depends on ddo_pkg for the heading limit.
`default_nettype none

module ddo_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic signed [31:0] pos_x,
	input wire logic signed [31:0] pos_y,
	input wire logic signed [18:0] heading,
	input wire logic               pose_valid,
	input wire logic               step_rejected
);

	logic               have_prev_q;
	logic signed [31:0] prev_x_q, prev_y_q;
	logic signed [18:0] prev_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
		end else if (out_valid && out_ready) begin
			have_prev_q <= 1'b1;
			prev_x_q    <= pos_x;
			prev_y_q    <= pos_y;
			prev_h_q    <= heading;
		end
	end

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(pos_x) && $stable(pos_y) && $stable(heading))
		else $error("stalled result item changed");

	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pose_valid && 20'(heading) <= ddo_pkg::PI_Q16
			&& 20'(heading) >= -ddo_pkg::PI_Q16)
		else $error("heading outside plus or minus pi or pose not valid");

	a_reject_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && step_rejected && have_prev_q |->
			pos_x == prev_x_q && pos_y == prev_y_q && heading == prev_h_q)
		else $error("rejected step moved the pose");

endmodule

bind differential_drive_odometry_core ddo_checker u_ddo_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.pos_x         (out_ch.pos_x),
	.pos_y         (out_ch.pos_y),
	.heading       (out_ch.heading),
	.pose_valid    (out_ch.pose_valid),
	.step_rejected (out_ch.step_rejected)
);

`default_nettype wire

// ===== sim/differential_drive_odometry_core_tb.sv =====
// Testbench for differential_drive_odometry_core: directed and random sample/pose items,
// checked against an in-bench dead-reckoning predictor. Needs ddo_pkg, ddo_if and the core.
`timescale 1ns / 100ps

module differential_drive_odometry_core_tb;

	typedef struct {
		bit                 cmd;
		logic signed [15:0] l;
		logic signed [15:0] r;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [18:0] h;
	} odo_item_t;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [18:0] h;
		logic               pv;
		logic               rej;
	} pose_t;

	localparam int  WATCHDOG_LIMIT = 5000;
	localparam int  SETTLE_CYCLES  = 80;
	localparam longint PI_Q = 205887;
	localparam longint TWO_PI_Q = 411774;
	localparam longint ONE_Q = 65536;
	localparam longint INV_GAIN = 652032874;
	localparam int  STEPS = 16;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [ddo_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [ddo_pkg::CFG_DATA_W-1:0] cfg_data;

	ddo_in_if  in_ch();
	ddo_out_if out_ch();

	differential_drive_odometry_core dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
	);

	// predictor state
	longint mpt, iwb;
	logic [15:0] last_l, last_r;
	bit have_last, started;
	longint px, py, th;

	pose_t poses_due[$];
	int errors = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	bit hold_rx = 0;
	int quiet_cycles = 0;
	logic signed [15:0] cur_l = 0, cur_r = 0;

	longint atan_tab[STEPS] = '{843314857, 497837829, 263043837, 133525159, 67021687,
		33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
		65536, 32768};

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic longint round_shift(longint v, int n);
		longint half;
		half = longint'(1) << (n - 1);
		if (v < 0)
			return -((-v + half) >> n);
		return (v + half) >> n;
	endfunction

	function automatic longint wrap_angle(longint a);
		if (a > PI_Q)
			return a - TWO_PI_Q;
		if (a < -PI_Q)
			return a + TWO_PI_Q;
		return a;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint floor_root(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	function automatic longint arcsine(longint s);
		longint c, cx, cy, z, nx;
		c = floor_root(64'd4294967296 - longint'(s * s));
		cx = c * 16384;
		cy = s * 16384;
		z = 0;
		for (int i = 0; i < STEPS; i++) begin
			if (cy > 0) begin
				nx = cx + (cy >>> i); cy = cy - (cx >>> i); z += atan_tab[i];
			end else begin
				nx = cx - (cy >>> i); cy = cy + (cx >>> i); z -= atan_tab[i];
			end
			cx = nx;
		end
		return round_shift(z, 14);
	endfunction

	task automatic rotate(longint a, output longint co, output longint si);
		bit flip;
		longint cx, cy, z, nx;
		flip = 0;
		cx = INV_GAIN;
		cy = 0;
		if (a > PI_Q / 2) begin
			a -= PI_Q; flip = 1;
		end else if (a < -(PI_Q / 2)) begin
			a += PI_Q; flip = 1;
		end
		z = a * 16384;
		for (int i = 0; i < STEPS; i++) begin
			if (z >= 0) begin
				nx = cx - (cy >>> i); cy = cy + (cx >>> i); z -= atan_tab[i];
			end else begin
				nx = cx + (cy >>> i); cy = cy - (cx >>> i); z += atan_tab[i];
			end
			cx = nx;
		end
		co = flip ? -cx : cx;
		si = flip ? -cy : cy;
	endtask

	task automatic dead_reckon(odo_item_t it);
		logic [15:0] tl, tr;
		longint dl, dr, ml, mr, diff, arg, ang, mid, mean, co, si;
		pose_t p;
		bit rej;
		rej = 0;
		if (it.cmd) begin
			px = it.x;
			py = it.y;
			th = wrap_angle(longint'(it.h));
			started = 1;
		end else begin
			dl = 0;
			dr = 0;
			if (have_last) begin
				tl = it.l - last_l;
				tr = it.r - last_r;
				dl = longint'(signed'(tl));
				dr = longint'(signed'(tr));
			end
			last_l = it.l;
			last_r = it.r;
			have_last = 1;
			if (!started)
				return;
			ml = dl * mpt;
			mr = dr * mpt;
			diff = round_shift(mr - ml, 8);
			arg = round_shift(diff * iwb, 16);
			if (arg > ONE_Q || arg < -ONE_Q) begin
				rej = 1;
			end else begin
				ang = arcsine(arg);
				mid = wrap_angle(th + (ang >>> 1));
				mean = round_shift(ml + mr, 9);
				rotate(mid, co, si);
				px = clamp32(px + round_shift(mean * co, 30));
				py = clamp32(py + round_shift(mean * si, 30));
				th = wrap_angle(th + ang);
			end
		end
		p.x = px[31:0];
		p.y = py[31:0];
		p.h = th[18:0];
		p.pv = 1;
		p.rej = rej;
		poses_due.push_back(p);
	endtask

	// sender: ready is sampled at the falling edge, the item moves at the next rising edge
	task automatic send_item(odo_item_t it);
		bit rdy;
		if ($urandom_range(99) < idle_pct) begin
			in_ch.valid <= 0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		in_ch.valid       <= 1;
		in_ch.command     <= it.cmd;
		in_ch.left_count  <= it.l;
		in_ch.right_count <= it.r;
		in_ch.new_x       <= it.x;
		in_ch.new_y       <= it.y;
		in_ch.new_heading <= it.h;
		do begin
			@(negedge clk);
			rdy = in_ch.ready;
			@(posedge clk);
		end while (!rdy);
		dead_reckon(it);
	endtask

	task automatic send_sample(logic signed [15:0] l, logic signed [15:0] r);
		odo_item_t it;
		it.cmd = 0; it.l = l; it.r = r;
		it.x = $urandom; it.y = $urandom; it.h = $urandom;
		cur_l = l;
		cur_r = r;
		send_item(it);
	endtask

	task automatic send_pose(logic signed [31:0] x, logic signed [31:0] y,
			logic signed [18:0] h);
		odo_item_t it;
		it.cmd = 1; it.x = x; it.y = y; it.h = h;
		it.l = $urandom; it.r = $urandom;
		send_item(it);
	endtask

	task automatic drain();
		in_ch.valid <= 0;
		while (poses_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [ddo_pkg::CFG_IDX_W-1:0] idx, longint val);
		cfg_we    <= 1;
		cfg_index <= idx;
		cfg_data  <= val[23:0];
		@(posedge clk);
		cfg_we <= 0;
		if (idx == ddo_pkg::CFG_METERS_PER_TICK)
			mpt = val;
		else
			iwb = val;
	endtask

	task automatic test_before_pose();
		send_sample(16'sd100, -16'sd100);
		send_sample(16'sd120, -16'sd90);
		send_pose(32'sd0, 32'sd0, 19'sd0);
		send_sample(16'sd200, 16'sd180);
		send_sample(16'sd200, 16'sd180);
		drain();
	endtask

	task automatic test_pose_extremes();
		send_pose(32'sh7fffffff, 32'sh80000000, 19'sd205887);
		send_sample(cur_l + 16'sd50, cur_r + 16'sd60);
		send_pose(32'sh80000000, 32'sh7fffffff, -19'sd205887);
		send_sample(cur_l + 16'sd50, cur_r + 16'sd40);
		send_pose(32'sh00010000, -32'sh00020000, 19'sd102944);
		send_sample(cur_l - 16'sd30, cur_r - 16'sd30);
		drain();
	endtask

	task automatic test_counter_wrap();
		send_sample(16'sh7ff0, 16'shfff0);
		send_sample(16'sh8010, 16'sh0010);
		send_sample(16'sh7ff0, 16'shfff0);
		send_sample(16'shffff, 16'sh7fff);
		send_sample(16'sh0000, 16'sh8000);
		drain();
	endtask

	task automatic test_rejection();
		send_sample(cur_l - 16'sd2000, cur_r + 16'sd2000);
		send_sample(cur_l + 16'sd3000, cur_r - 16'sd3000);
		send_sample(cur_l + 16'sd10, cur_r + 16'sd12);
		drain();
	endtask

	task automatic test_saturation();
		write_reg(ddo_pkg::CFG_METERS_PER_TICK, 24'hffffff);
		write_reg(ddo_pkg::CFG_INV_WHEEL_BASE, 24'd1);
		send_pose(32'sh7ffffff0, 32'sh80000010, 19'sd0);
		send_sample(cur_l + 16'sd1000, cur_r + 16'sd1000);
		send_pose(32'sh7ffffff0, 32'sh80000010, -19'sd102943);
		send_sample(cur_l + 16'sd1000, cur_r + 16'sd1000);
		send_sample(cur_l - 16'sd32768, cur_r + 16'sd32767);
		drain();
		write_reg(ddo_pkg::CFG_METERS_PER_TICK, 24'd1);
		write_reg(ddo_pkg::CFG_INV_WHEEL_BASE, 24'hffffff);
		send_sample(cur_l + 16'sd100, cur_r + 16'sd300);
		send_sample(cur_l - 16'sd5, cur_r + 16'sd5);
		drain();
	endtask

	task automatic random_items(int count);
		int kind;
		for (int n = 0; n < count; n++) begin
			kind = $urandom_range(99);
			if (kind < 7)
				send_pose($urandom, $urandom, 19'($urandom_range(411774)) - 19'sd205887);
			else if (kind < 15)
				send_sample($urandom, $urandom);
			else
				send_sample(cur_l + 16'($urandom_range(1200)) - 16'sd600,
					cur_r + 16'($urandom_range(1200)) - 16'sd600);
		end
	endtask

	task automatic test_random_phase(int idle, int stall, longint m, longint w, int count);
		write_reg(ddo_pkg::CFG_METERS_PER_TICK, m);
		write_reg(ddo_pkg::CFG_INV_WHEEL_BASE, w);
		idle_pct  = idle;
		stall_pct = stall;
		random_items(count);
		drain();
	endtask

	// receiver holds off long enough that the core backs up into its input
	task automatic test_backpressure();
		idle_pct  = 0;
		stall_pct = 0;
		fork
			begin
				hold_rx = 1;
				repeat (400) @(posedge clk);
				hold_rx = 0;
			end
			random_items(20);
		join
		drain();
	endtask

	always @(posedge clk)
		out_ch.ready <= !hold_rx && ($urandom_range(99) >= stall_pct);

	always @(negedge clk) begin
		pose_t p;
		if (out_ch.valid && out_ch.ready) begin
			if (poses_due.size() == 0) begin
				$error("unexpected result: pos_x %0d", out_ch.pos_x);
				errors++;
			end else begin
				p = poses_due.pop_front();
				if (out_ch.pos_x !== p.x) begin
					$error("pos_x expected %0d actual %0d", p.x, out_ch.pos_x);
					errors++;
				end
				if (out_ch.pos_y !== p.y) begin
					$error("pos_y expected %0d actual %0d", p.y, out_ch.pos_y);
					errors++;
				end
				if (out_ch.heading !== p.h) begin
					$error("heading expected %0d actual %0d", p.h, out_ch.heading);
					errors++;
				end
				if (out_ch.pose_valid !== p.pv) begin
					$error("pose_valid expected %0d actual %0d", p.pv, out_ch.pose_valid);
					errors++;
				end
				if (out_ch.step_rejected !== p.rej) begin
					$error("step_rejected expected %0d actual %0d", p.rej,
						out_ch.step_rejected);
					errors++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		arst_n            <= 0;
		cfg_we            <= 0;
		cfg_index         <= '0;
		cfg_data          <= '0;
		in_ch.valid       <= 0;
		in_ch.command     <= 0;
		in_ch.left_count  <= '0;
		in_ch.right_count <= '0;
		in_ch.new_x       <= '0;
		in_ch.new_y       <= '0;
		in_ch.new_heading <= '0;
		mpt = 7457;
		iwb = 292571;
		last_l = 0;
		last_r = 0;
		have_last = 0;
		started = 0;
		px = 0;
		py = 0;
		th = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		test_before_pose();
		test_pose_extremes();
		test_counter_wrap();
		test_rejection();
		test_saturation();
		test_random_phase(0, 0, 7457, 292571, 420);
		test_random_phase(82, 0, 1, 16777215, 400);
		test_random_phase(0, 82, 16777215, 1, 400);
		test_random_phase(8, 8, 50000, 200000, 420);
		test_backpressure();

		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
